[design/sndf_pkg.sv]
// Package for the signed number to digit frames block.
// Holds field widths, the minus-sign code and the reciprocal constants
// used for the decimal split. No dependencies.
package sndf_pkg;

	localparam int unsigned NUM_W   = 16;
	localparam int unsigned POS_W   = 3;
	localparam int unsigned CODE_W  = 4;
	localparam int unsigned TDATA_W = 8;
	localparam int unsigned FRAMES  = 4;
	localparam int unsigned FIDX_W  = 2;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [NUM_W-1:0]  mag_t;

	// Code shown in the fourth place for a negative number.
	localparam code_t MINUS_CODE = code_t'(10);

	// Quotients by 10, 100 and 1000 as multiply and shift; exact for
	// magnitudes up to 32768.
	localparam logic [16:0] RECIP_10    = 17'd52429;
	localparam int unsigned SHIFT_10    = 19;
	localparam logic [16:0] RECIP_100   = 17'd5243;
	localparam int unsigned SHIFT_100   = 19;
	localparam logic [16:0] RECIP_1000  = 17'd67109;
	localparam int unsigned SHIFT_1000  = 26;
	// Quotient by 10 of a value below 64.
	localparam logic [3:0]  RECIP_SMALL = 4'd13;
	localparam int unsigned SHIFT_SMALL = 7;

endpackage

[design/signed_number_to_digit_frames.sv]
// Top level of the signed number to digit frames block.
// Depends on sndf_pkg for widths, the minus-sign code and reciprocal constants.
//
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata) takes one signed 16-bit number
//   per item. Master channel (m_tvalid/m_tready/m_tdata/m_tlast) emits four
//   frames per number: positions 1..4, ones digit first. A non-negative
//   number shows its value modulo 10000; a negative number shows the low
//   three digits of its magnitude and the minus-sign code 10 in position 4.
//   m_tlast marks the fourth frame.
// Path: the first frame of a number passes through the input register, the
//   quotient register and the frame buffer before it is on m_tdata.
// Overlap: the four frames of each number leave through the single master
//   channel; the input and quotient stages take the next numbers while the
//   frame buffer is still draining.
// Reset: arst_n clears all valid flags and the frame counter at once; the
//   block is ready for items as soon as reset is released.
// Stall: when m_tready is low the current frame holds; the stages ahead fill
//   up and s_tready drops once both are full.
module signed_number_to_digit_frames (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [15:0] s_tdata,  // [15:0] number_value
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [2:0] digit_position, [6:3] digit_code, [7] zero
	output logic       m_tlast    // last_frame
);

	// Stage 1: magnitude and sign of the accepted number.
	logic                 v_s1;
	logic                 neg_s1;
	sndf_pkg::mag_t       mag_s1;
	// Stage 2: quotients by 10, 100, 1000.
	logic                 v_s2;
	logic                 neg_s2;
	sndf_pkg::mag_t       mag_s2;
	logic [12:0]          q1_s2;
	logic [9:0]           q2_s2;
	logic [5:0]           q3_s2;
	// Frame buffer: four digit codes and the frame index being shown.
	logic                 buf_valid_q;
	sndf_pkg::code_t      digits_q [sndf_pkg::FRAMES];
	logic [sndf_pkg::FIDX_W-1:0] fidx_q;

	logic adv_buf, adv_s2, adv_s1;
	logic frame_done;

	// Free the buffer when its last frame leaves.
	assign frame_done = buf_valid_q && m_tready && (fidx_q == sndf_pkg::FIDX_W'(sndf_pkg::FRAMES - 1));
	assign adv_buf    = !buf_valid_q || frame_done;
	assign adv_s2     = !v_s2 || adv_buf;
	assign adv_s1     = !v_s1 || adv_s2;
	assign s_tready   = adv_s1;

	// Input stage: take the magnitude, keeping 32768 for the most negative value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			neg_s1 <= s_tdata[15];
			mag_s1 <= s_tdata[15] ? (16'd0 - s_tdata) : s_tdata;
		end
	end

	// Quotient stage: one multiply per divisor, all in parallel.
	logic [33:0] p1, p2, p3;
	always_comb begin
		p1 = {18'd0, mag_s1} * {17'd0, sndf_pkg::RECIP_10};
		p2 = {18'd0, mag_s1} * {17'd0, sndf_pkg::RECIP_100};
		p3 = {18'd0, mag_s1} * {17'd0, sndf_pkg::RECIP_1000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			neg_s2 <= neg_s1;
			mag_s2 <= mag_s1;
			q1_s2  <= 13'(p1 >> sndf_pkg::SHIFT_10);
			q2_s2  <= 10'(p2 >> sndf_pkg::SHIFT_100);
			q3_s2  <= 6'(p3 >> sndf_pkg::SHIFT_1000);
		end
	end

	// Digit stage: remainders by shift-and-add times ten.
	logic [15:0] d0_w;
	logic [12:0] d1_w;
	logic [9:0]  d2_w;
	logic [9:0]  q3x_w;
	logic [5:0]  q4_w;
	logic [5:0]  d3_w;
	always_comb begin
		d0_w  = mag_s2 - ({3'd0, q1_s2} << 3) - ({3'd0, q1_s2} << 1);
		d1_w  = q1_s2 - ({3'd0, q2_s2} << 3) - ({3'd0, q2_s2} << 1);
		d2_w  = q2_s2 - ({4'd0, q3_s2} << 3) - ({4'd0, q3_s2} << 1);
		q3x_w = {4'd0, q3_s2} * {6'd0, sndf_pkg::RECIP_SMALL};
		q4_w  = 6'(q3x_w >> sndf_pkg::SHIFT_SMALL);
		d3_w  = q3_s2 - (q4_w << 3) - (q4_w << 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			fidx_q      <= '0;
		end else begin
			if (adv_buf) begin
				buf_valid_q <= v_s2;
				fidx_q      <= '0;
			end else if (m_tready) begin
				// advance to the next frame of this number
				fidx_q <= fidx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_buf && v_s2) begin
			digits_q[0] <= d0_w[3:0];
			digits_q[1] <= d1_w[3:0];
			digits_q[2] <= d2_w[3:0];
			digits_q[3] <= neg_s2 ? sndf_pkg::MINUS_CODE : d3_w[3:0];
		end
	end

	assign m_tvalid = buf_valid_q;
	assign m_tlast  = (fidx_q == sndf_pkg::FIDX_W'(sndf_pkg::FRAMES - 1));
	assign m_tdata  = {1'b0, digits_q[fidx_q], {1'b0, fidx_q} + 3'd1};

endmodule

[design/sndf_checker.sv]
// Port-level checker for signed_number_to_digit_frames, with its bind.
// Depends only on the top level's ports.
module sndf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// Frames of one number come in position order.
	a_pos_advance: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
		m_tvalid && (m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1))
		else $error("frame position did not advance");

	// Last flag exactly on position 4.
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[2:0] == 3'd4)))
		else $error("last flag and position disagree");

	// A run starts at position 1 after its predecessor ends.
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast ##1 m_tvalid |-> m_tdata[2:0] == 3'd1)
		else $error("run did not start at position 1");

	// Minus sign only in the last frame; codes stay at or below 10.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:3] < 4'd10) || (m_tdata[6:3] == 4'd10 && m_tlast))
		else $error("bad digit code");

	// Position is always 1 to 4.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] != 3'd0) && (m_tdata[2:0] < 3'd5))
		else $error("position out of range");

endmodule

bind signed_number_to_digit_frames sndf_checker u_sndf_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

[verif/signed_number_to_digit_frames_tb.sv]
// Testbench for signed_number_to_digit_frames: drives signed numbers on the
// stream input and checks every digit frame against an internal predictor.
// Depends on sndf_pkg and the RTL of the block; nothing else.
`timescale 1ns / 100ps

module signed_number_to_digit_frames_tb;

	// Cycles without any accepted item before the run is declared hung.
	// Longest quiet stretch is a long stall plus pipeline latency.
	localparam int unsigned HANG_LIMIT    = 2000;
	localparam int unsigned RANDOM_ITEMS  = 130;
	localparam int unsigned MAX_REPORTS   = 10;
	localparam int unsigned DRAIN_CYCLES  = 8;

	// One expected display frame, tagged with the number it came from.
	typedef struct packed {
		logic signed [sndf_pkg::NUM_W-1:0] number;
		logic [sndf_pkg::POS_W-1:0]        pos;
		sndf_pkg::code_t                   code;
		logic                              last;
	} digit_frame_t;

	// Splits accepted numbers into expected frames and checks arriving frames
	// against them in order.
	class digit_frame_board;
		digit_frame_t frames_due[$];
		int unsigned  mismatches;
		int unsigned  frames_checked;

		function new();
			mismatches     = 0;
			frames_checked = 0;
		endfunction

		// Decimal split: ones place first; a negative number shows the low three
		// digits of its magnitude and the minus sign in the fourth place.
		function void note_number(logic signed [sndf_pkg::NUM_W-1:0] number);
			logic            negative;
			int unsigned     magnitude;
			int unsigned     scale;
			digit_frame_t    f;
			negative  = number[sndf_pkg::NUM_W-1];
			// -32768 must give 32768, so widen before negating
			magnitude = negative ? (32'h10000 - {16'h0, number}) : {16'h0, number};
			scale     = 1;
			for (int k = 0; k < int'(sndf_pkg::FRAMES); k++) begin
				f.number = number;
				f.pos    = sndf_pkg::POS_W'(k + 1);
				f.code   = sndf_pkg::code_t'((magnitude / scale) % 10);
				f.last   = (k == int'(sndf_pkg::FRAMES) - 1);
				if (negative && k == int'(sndf_pkg::FRAMES) - 1) begin
					f.code = sndf_pkg::MINUS_CODE;
				end
				frames_due.push_back(f);
				scale = scale * 10;
			end
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("%0t ns: %s", $time, msg);
			end
		endfunction

		function void check_frame(logic [sndf_pkg::POS_W-1:0] pos, sndf_pkg::code_t code,
			logic last);
			digit_frame_t want;
			frames_checked++;
			if (frames_due.size() == 0) begin
				flag($sformatf("unexpected frame pos %0d code %0d last %0b",
					pos, code, last));
				return;
			end
			want = frames_due.pop_front();
			if (pos !== want.pos) begin
				flag($sformatf("number %0d: position expected %0d, got %0d",
					want.number, want.pos, pos));
			end
			if (code !== want.code) begin
				flag($sformatf("number %0d pos %0d: code expected %0d, got %0d",
					want.number, want.pos, want.code, code));
			end
			if (last !== want.last) begin
				flag($sformatf("number %0d pos %0d: last expected %0b, got %0b",
					want.number, want.pos, want.last, last));
			end
		endfunction

		function int unsigned pending();
			return frames_due.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [sndf_pkg::NUM_W-1:0]    s_tdata;   // [15:0] number_value
	logic                          m_tvalid;
	logic                          m_tready;
	logic [sndf_pkg::TDATA_W-1:0]  m_tdata;   // [2:0] digit_position, [6:3] digit_code, [7] zero
	logic                          m_tlast;   // last_frame

	digit_frame_board board;
	int unsigned      numbers_in;
	int unsigned      negatives_in;
	int unsigned      idle_cycles;
	bit               smooth;       // when set, neither side inserts gaps

	signed_number_to_digit_frames uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Pick an idle length: mostly none or short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (smooth) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Offer one number after a random gap; hold it until the block takes it.
	// Inputs move on the falling edge so the rising edge sees them settled.
	task automatic send_number(input logic [sndf_pkg::NUM_W-1:0] value);
		int unsigned gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			s_tdata  = sndf_pkg::NUM_W'($urandom());  // junk while idle, must be ignored
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = value;
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	// Draw a number that lands on an interesting spot of the decimal split.
	function automatic logic [sndf_pkg::NUM_W-1:0] pick_number();
		int          val;
		int unsigned kind;
		int          edges [9] = '{999, 1000, 9999, 10000, 19999, 20000, 29999,
			30000, 32767};
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			return sndf_pkg::NUM_W'($urandom());
		end else if (kind < 6) begin
			// short numbers with both signs
			val = int'($urandom_range(0, 2200)) - 1100;
		end else if (kind < 8) begin
			// near digit rollovers and the top of the range
			val = edges[$urandom_range(0, 8)] - int'($urandom_range(0, 3));
			if ($urandom_range(0, 1)) begin
				val = -val;
			end
		end else begin
			val = -int'($urandom_range(1, 32768));
		end
		return val[sndf_pkg::NUM_W-1:0];
	endfunction

	// Hold the sender until every frame owed so far has come out.
	task automatic drain_frames();
		while (board.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	// Receiver: stall at random for a span, then take frames again.
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		stall    = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall != 0) begin
				m_tready = 1'b0;
				stall--;
			end else begin
				m_tready = 1'b1;
				stall    = pick_gap();
			end
		end
	end

	// Sample both channels on the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				board.note_number(s_tdata);
				numbers_in++;
				if (s_tdata[sndf_pkg::NUM_W-1]) begin
					negatives_in++;
				end
			end
			if (m_tvalid && m_tready) begin
				board.check_frame(m_tdata[sndf_pkg::POS_W-1:0],
					m_tdata[sndf_pkg::POS_W+sndf_pkg::CODE_W-1:sndf_pkg::POS_W], m_tlast);
			end
		end
	end

	// Watchdog: end the run if nothing moves on either channel for too long.
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < HANG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("timeout: no item moved for %0d cycles", HANG_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [sndf_pkg::NUM_W-1:0] corner_numbers [$] = '{
			16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
			16'd9999, 16'd10000, 16'd12345, 16'd20000, 16'd32767,
			-16'sd1, -16'sd9, -16'sd10, -16'sd999, -16'sd1000, -16'sd12345,
			-16'sd32767, 16'h8000, 16'h5555, 16'hAAAA
		};
		board        = new();
		numbers_in   = 0;
		negatives_in = 0;
		smooth       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		arst_n       = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: digit rollovers, extremes of both signs, the most negative
		// number, and alternating bit patterns.
		foreach (corner_numbers[i]) begin
			send_number(corner_numbers[i]);
		end
		@(negedge clk);
		s_tvalid = 1'b0;
		drain_frames();

		// Random: idle in the first and last parts, back to back in the middle;
		// drain fully every fifty numbers.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			smooth = (i >= 60 && i < 90);
			send_number(pick_number());
			if (i % 50 == 49) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				drain_frames();
			end
		end
		@(negedge clk);
		s_tvalid = 1'b0;
		smooth   = 1'b0;

		// Wait out the last frames, then watch a little longer for extras.
		drain_frames();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d numbers (%0d negative) and checked %0d frames,",
			numbers_in, negatives_in, board.frames_checked);
		$display("with random and long stalls on both channels; %0d mismatches.",
			board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[signed_number_to_digit_frames.f]
design/sndf_pkg.sv
design/signed_number_to_digit_frames.sv
design/sndf_checker.sv
verif/signed_number_to_digit_frames_tb.sv
